// ===== hw/rtl/bfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants for the FNV-1a Bloom filter core.
// ----------------------------------------------------------------------------
package bfc_pkg;

	localparam int unsigned DEF_MAX_BITS   = 65536;
	localparam int unsigned DEF_MAX_HASHES = 8;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam int unsigned FB_W      = 17;
	localparam int unsigned HF_W      = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 17;

	localparam logic [FB_W-1:0] FB_RESET = 17'd65536;
	localparam logic [HF_W-1:0] HF_RESET = 4'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_FUNCS  = 2'd1;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// dividend bits walked by the serial modulo
	localparam int unsigned MOD_STEPS = 32;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_PROBE,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic upd;
		logic load;
		logic step;
		logic shift;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/bfc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_cell
// One hash lane: running FNV-1a hash, bit-serial modulo and a shift stage
// that passes bit positions along the chain.
// ----------------------------------------------------------------------------
module bfc_cell #(
	parameter int unsigned MAX_BITS = bfc_pkg::DEF_MAX_BITS,
	parameter logic [31:0] SEED     = bfc_pkg::FNV_BASIS,
	localparam int unsigned MW      = $clog2(MAX_BITS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bfc_pkg::cell_ctl_t  ctl,
	input  logic [7:0]          key_byte,
	input  logic [MW-1:0]       modulus,
	input  logic [MW-1:0]       rem_in,
	output logic [MW-1:0]       rem_out
);

	logic [31:0] hash_q;
	logic [31:0] div_q;
	logic [MW-1:0] rem_q;
	logic [31:0] mix;
	logic [31:0] hash_nx;
	logic [MW:0] trial;
	logic [MW-1:0] rem_nx;

	always_comb begin
		mix     = hash_q ^ {24'd0, key_byte};
		hash_nx = ctl.upd ? 32'(mix * bfc_pkg::FNV_PRIME) : hash_q;
		trial   = {rem_q, div_q[31]};
		if (trial >= {1'b0, modulus}) begin
			trial = trial - {1'b0, modulus};
		end
		rem_nx  = trial[MW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= SEED;
		end else if (ctl.load) begin
			hash_q <= SEED;
		end else if (ctl.upd) begin
			hash_q <= hash_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			div_q <= hash_nx;
			rem_q <= '0;
		end else if (ctl.step) begin
			div_q <= {div_q[30:0], 1'b0};
			rem_q <= rem_nx;
		end else if (ctl.shift) begin
			rem_q <= rem_in;
		end
	end

	assign rem_out = rem_q;

endmodule

// ===== hw/rtl/bfc_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_store
// Single-bit filter store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfc_store #(
	parameter int unsigned MAX_BITS = bfc_pkg::DEF_MAX_BITS,
	localparam int unsigned AW      = $clog2(MAX_BITS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [MAX_BITS];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/bloom_filter_fnv1a_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_fnv1a_core
// Bloom filter over a bit store, keyed by seeded FNV-1a hashes.
//
// Input channel: one key byte per transfer with opcode, byte_valid and
// last_byte. Only the opcode of the last transfer of a key counts.
// Output channel: one found transfer per query key; adds give none.
// Key bytes that are not last are taken one per cycle while the core is idle; each hash cell
// updates its running hash in that cycle.
// A last transfer starts the bit-serial modulo (all cells at once), then
// positions shift out of the cell chain to the store, one per active
// hash, and a drain state settles the last read before the next
// transfer is taken.
// After reset the store is cleared one bit a cycle, all MAX_BITS bits, with
// the input stalled; configuration writes are taken throughout.
// A stalled result waits until the output register is free; the input stays
// stalled meanwhile, so the next key's bytes wait as well.
// ----------------------------------------------------------------------------
module bloom_filter_fnv1a_core #(
	parameter int unsigned MAX_BITS   = bfc_pkg::DEF_MAX_BITS,
	parameter int unsigned MAX_HASHES = bfc_pkg::DEF_MAX_HASHES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfc_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [7:0]                    key_byte,
	input  logic                          byte_valid,
	input  logic                          last_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found
);

	localparam int unsigned MW = $clog2(MAX_BITS + 1);
	localparam int unsigned AW = $clog2(MAX_BITS);
	localparam int unsigned HW = $clog2(MAX_HASHES + 1);
	localparam int unsigned SW = $clog2(bfc_pkg::MOD_STEPS);

	bfc_pkg::state_t state_q, state_nx;

	logic [bfc_pkg::FB_W-1:0] fb_q;
	logic [bfc_pkg::HF_W-1:0] hf_q;
	logic [MW-1:0] modulus;
	logic [HW-1:0] nhash;

	logic [AW-1:0] clr_q;
	logic [SW-1:0] step_q;
	logic [HW-1:0] probe_q;
	logic          op_q;
	logic          hit_q;
	logic          rd_s1;
	logic          out_valid_q;
	logic          found_q;

	logic          accept;
	logic          out_free;
	logic          hit_now;
	logic          out_load;
	bfc_pkg::cell_ctl_t ctl;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic          mem_rdata;

	logic [MW-1:0] rem [MAX_HASHES+1];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q <= bfc_pkg::FB_RESET;
			hf_q <= bfc_pkg::HF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bfc_pkg::CFG_FILTER_BITS: fb_q <= cfg_data[bfc_pkg::FB_W-1:0];
				bfc_pkg::CFG_HASH_FUNCS:  hf_q <= cfg_data[bfc_pkg::HF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fb_q == '0) begin
			modulus = MW'(1);
		end else if (32'(fb_q) > MAX_BITS) begin
			modulus = MW'(MAX_BITS);
		end else begin
			modulus = MW'(fb_q);
		end
		if (hf_q == '0) begin
			nhash = HW'(1);
		end else if (32'(hf_q) > MAX_HASHES) begin
			nhash = HW'(MAX_HASHES);
		end else begin
			nhash = HW'(hf_q);
		end
	end

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign hit_now  = hit_q && (!rd_s1 || mem_rdata);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bfc_pkg::ST_CLEAR: begin
				if (clr_q == AW'(MAX_BITS - 1)) state_nx = bfc_pkg::ST_IDLE;
			end
			bfc_pkg::ST_IDLE: begin
				if (in_valid && last_byte) state_nx = bfc_pkg::ST_MOD;
			end
			bfc_pkg::ST_MOD: begin
				if (step_q == SW'(bfc_pkg::MOD_STEPS - 1)) state_nx = bfc_pkg::ST_PROBE;
			end
			bfc_pkg::ST_PROBE: begin
				if (probe_q == nhash - HW'(1)) state_nx = bfc_pkg::ST_DRAIN;
			end
			bfc_pkg::ST_DRAIN: begin
				if (op_q == bfc_pkg::OP_ADD || out_free) begin
					state_nx = bfc_pkg::ST_IDLE;
				end else begin
					state_nx = bfc_pkg::ST_HOLD;
				end
			end
			bfc_pkg::ST_HOLD: begin
				if (out_free) state_nx = bfc_pkg::ST_IDLE;
			end
			default: state_nx = bfc_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		in_stall  = 1'b1;
		ctl       = '0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 1'b0;
		mem_raddr = rem[0][AW-1:0];
		out_load  = 1'b0;
		case (state_q)
			bfc_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			bfc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				ctl.upd  = accept && byte_valid;
				ctl.load = accept && last_byte;
			end
			bfc_pkg::ST_MOD: begin
				ctl.step = 1'b1;
			end
			bfc_pkg::ST_PROBE: begin
				ctl.shift = 1'b1;
				mem_we    = (op_q == bfc_pkg::OP_ADD);
				mem_waddr = rem[0][AW-1:0];
				mem_wdata = 1'b1;
			end
			bfc_pkg::ST_DRAIN: begin
				out_load = (op_q == bfc_pkg::OP_QUERY) && out_free;
			end
			bfc_pkg::ST_HOLD: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bfc_pkg::ST_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			probe_q     <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == bfc_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			step_q  <= (state_q == bfc_pkg::ST_MOD) ? step_q + SW'(1) : '0;
			probe_q <= (state_q == bfc_pkg::ST_PROBE) ? probe_q + HW'(1) : '0;
			rd_s1   <= (state_q == bfc_pkg::ST_PROBE);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q  <= opcode;
			hit_q <= 1'b1;
		end else begin
			hit_q <= hit_now;
		end
		if (out_load) begin
			found_q <= (state_q == bfc_pkg::ST_HOLD) ? hit_q : hit_now;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

	// hash cell chain; positions shift towards cell 0
	assign rem[MAX_HASHES] = '0;

	for (genvar i = 0; i < MAX_HASHES; i++) begin : g_cell
		bfc_cell #(
			.MAX_BITS (MAX_BITS),
			.SEED     (bfc_pkg::FNV_BASIS ^ 32'(i))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.key_byte (key_byte),
			.modulus  (modulus),
			.rem_in   (rem[i+1]),
			.rem_out  (rem[i])
		);
	end

	bfc_store #(
		.MAX_BITS (MAX_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
